>>> hdl/ajfa_pkg.sv
// Shared types, codes and the joining table of the Arabic joining form assigner.
package ajfa_pkg;

    // Default sizes for the top-level parameters.
    localparam int MAX_RUN_DEF       = 4096;
    localparam int CONTEXT_LIMIT_DEF = 5;

    // Fixed field widths of the stream payload.
    localparam int KIND_W  = 2;
    localparam int JT_W    = 3;
    localparam int FORM_W  = 3;
    localparam int POS_W   = 12;
    localparam int STATE_W = 3;

    // Stream bus widths.
    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = KIND_W;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 1;

    // Joining table geometry: seven states by six non-transparent joining types.
    localparam int JT_COUNT   = 6;
    localparam int TABLE_SIZE = 42;

    // Item kinds.
    typedef enum logic [KIND_W-1:0] {
        KIND_START = 2'd0,
        KIND_PRE   = 2'd1,
        KIND_TEXT  = 2'd2,
        KIND_POST  = 2'd3
    } kind_t;

    // Joining type codes.
    localparam logic [JT_W-1:0] JT_NONE        = 3'd0;
    localparam logic [JT_W-1:0] JT_TRANSPARENT = 3'd6;

    // Initial joining machine state.
    localparam logic [STATE_W-1:0] JS_START = 3'd0;

    // Positional forms.
    typedef enum logic [FORM_W-1:0] {
        F_NONE = 3'd0,
        F_ISOL = 3'd1,
        F_FINA = 3'd2,
        F_FIN2 = 3'd3,
        F_FIN3 = 3'd4,
        F_MEDI = 3'd5,
        F_MED2 = 3'd6,
        F_INIT = 3'd7
    } form_t;

    // Where the run currently stands.
    typedef enum logic [1:0] {
        PH_BEFORE = 2'd0,
        PH_TEXT   = 2'd1,
        PH_POST   = 2'd2
    } phase_t;

    // One table entry: rewrite of the previous character, form of this one, next state.
    typedef struct packed {
        form_t               prev_form;
        form_t               cur_form;
        logic [STATE_W-1:0]  state_after;
    } join_entry_t;

    // Fixed-width control state of the joining machine.
    typedef struct packed {
        logic [STATE_W-1:0] joining_state;
        logic               have_previous;
        logic               context_done;
        phase_t             phase;
    } ctl_t;

    // One result item.
    typedef struct packed {
        logic              valid;
        form_t             current_form;
        logic [POS_W-1:0]  text_position;
        logic              fix_previous;
        logic [POS_W-1:0]  previous_position;
        form_t             previous_form;
    } res_t;

    localparam join_entry_t JOIN_TABLE [TABLE_SIZE] = '{
        '{F_NONE, F_NONE, 3'd0}, '{F_NONE, F_ISOL, 3'd2}, '{F_NONE, F_ISOL, 3'd1},
        '{F_NONE, F_ISOL, 3'd2}, '{F_NONE, F_ISOL, 3'd1}, '{F_NONE, F_ISOL, 3'd6},

        '{F_NONE, F_NONE, 3'd0}, '{F_NONE, F_ISOL, 3'd2}, '{F_NONE, F_ISOL, 3'd1},
        '{F_NONE, F_ISOL, 3'd2}, '{F_NONE, F_FIN2, 3'd5}, '{F_NONE, F_ISOL, 3'd6},

        '{F_NONE, F_NONE, 3'd0}, '{F_NONE, F_ISOL, 3'd2}, '{F_INIT, F_FINA, 3'd1},
        '{F_INIT, F_FINA, 3'd3}, '{F_INIT, F_FINA, 3'd4}, '{F_INIT, F_FINA, 3'd6},

        '{F_NONE, F_NONE, 3'd0}, '{F_NONE, F_ISOL, 3'd2}, '{F_MEDI, F_FINA, 3'd1},
        '{F_MEDI, F_FINA, 3'd3}, '{F_MEDI, F_FINA, 3'd4}, '{F_MEDI, F_FINA, 3'd6},

        '{F_NONE, F_NONE, 3'd0}, '{F_NONE, F_ISOL, 3'd2}, '{F_MED2, F_ISOL, 3'd1},
        '{F_MED2, F_ISOL, 3'd2}, '{F_MED2, F_FIN2, 3'd5}, '{F_MED2, F_ISOL, 3'd6},

        '{F_NONE, F_NONE, 3'd0}, '{F_NONE, F_ISOL, 3'd2}, '{F_ISOL, F_ISOL, 3'd1},
        '{F_ISOL, F_ISOL, 3'd2}, '{F_ISOL, F_FIN2, 3'd5}, '{F_ISOL, F_ISOL, 3'd6},

        '{F_NONE, F_NONE, 3'd0}, '{F_NONE, F_ISOL, 3'd2}, '{F_NONE, F_ISOL, 3'd1},
        '{F_NONE, F_ISOL, 3'd2}, '{F_NONE, F_FIN3, 3'd5}, '{F_NONE, F_ISOL, 3'd6}
    };

    // Table lookup by state and non-transparent joining type.
    function automatic join_entry_t join_lookup(input logic [STATE_W-1:0] st,
                                                input logic [JT_W-1:0] jt);
        logic [5:0]  idx;
        join_entry_t entry;
        idx = 6'(st) * 6'(JT_COUNT) + 6'(jt);
        if (idx < 6'(TABLE_SIZE)) begin
            entry = JOIN_TABLE[idx];
        end
        else begin
            entry = '{F_NONE, F_NONE, JS_START};
        end
        return entry;
    endfunction

endpackage

>>> hdl/ajfa_step.sv
// Combinational step of the joining machine: next state and result for one character.
module ajfa_step
    import ajfa_pkg::*;
#(
    parameter int MAX_RUN       = MAX_RUN_DEF,
    parameter int CONTEXT_LIMIT = CONTEXT_LIMIT_DEF,
    localparam int CNT_W = $clog2(MAX_RUN + 1),
    localparam int IDX_W = $clog2(MAX_RUN),
    localparam int CTX_W = $clog2(CONTEXT_LIMIT + 1)
)
(
    input  kind_t             kind,
    input  logic [JT_W-1:0]   joining_type,
    input  ctl_t              ctl,
    input  logic [CNT_W-1:0]  text_counter,
    input  logic [IDX_W-1:0]  previous_index,
    input  logic [CTX_W-1:0]  context_inspected,
    output ctl_t              ctl_next,
    output logic [CNT_W-1:0]  text_counter_next,
    output logic [IDX_W-1:0]  previous_index_next,
    output logic [CTX_W-1:0]  context_inspected_next,
    output res_t              result
);

    logic [JT_W-1:0]        jt;
    logic                   transparent;
    join_entry_t            entry;
    join_entry_t            pre_entry;
    logic [IDX_W-1:0]       pos;
    logic [IDX_W+POS_W-1:0] pos_wide;
    logic [IDX_W+POS_W-1:0] prev_wide;
    logic                   post_done;
    logic [CTX_W-1:0]       post_inspected;

    // The unused joining type code behaves as non-joining.
    assign jt          = (joining_type > JT_TRANSPARENT) ? JT_NONE : joining_type;
    assign transparent = (jt == JT_TRANSPARENT);

    // Lookups for the current state and for the seeding of pre-context.
    assign entry     = join_lookup(ctl.joining_state, jt);
    assign pre_entry = join_lookup(JS_START, jt);

    // Positions are reported in the 12-bit field width.
    assign pos       = text_counter[IDX_W-1:0];
    assign pos_wide  = (IDX_W+POS_W)'(pos);
    assign prev_wide = (IDX_W+POS_W)'(previous_index);

    // Post-context starts its own count when it first appears.
    assign post_done      = (ctl.phase == PH_POST) ? ctl.context_done : 1'b0;
    assign post_inspected = (ctl.phase == PH_POST) ? context_inspected : '0;

    always_comb
    begin
        ctl_next               = ctl;
        text_counter_next      = text_counter;
        previous_index_next    = previous_index;
        context_inspected_next = context_inspected;
        result                 = '0;
        result.current_form    = F_NONE;
        result.previous_form   = F_NONE;

        case (kind)
            KIND_START:
            begin
                ctl_next.joining_state = JS_START;
                ctl_next.have_previous = 1'b0;
                ctl_next.context_done  = 1'b0;
                ctl_next.phase         = PH_BEFORE;
                text_counter_next      = '0;
                previous_index_next    = '0;
                context_inspected_next = '0;
            end

            KIND_PRE:
            begin
                // Nearest pre-context character seeds the machine.
                if (ctl.phase == PH_BEFORE && !ctl.context_done &&
                    context_inspected < CTX_W'(CONTEXT_LIMIT))
                begin
                    context_inspected_next = context_inspected + 1'b1;
                    if (!transparent)
                    begin
                        ctl_next.joining_state = pre_entry.state_after;
                        ctl_next.context_done  = 1'b1;
                    end
                end
            end

            KIND_TEXT:
            begin
                if (ctl.phase != PH_POST)
                begin
                    if (ctl.phase == PH_BEFORE)
                    begin
                        ctl_next.phase         = PH_TEXT;
                        ctl_next.context_done  = 1'b0;
                        context_inspected_next = '0;
                    end
                    if (text_counter < CNT_W'(MAX_RUN))
                    begin
                        text_counter_next    = text_counter + 1'b1;
                        result.valid         = 1'b1;
                        result.text_position = pos_wide[POS_W-1:0];
                        // Transparent characters leave the machine alone.
                        if (!transparent)
                        begin
                            result.current_form = entry.cur_form;
                            if (entry.prev_form != F_NONE && ctl.have_previous)
                            begin
                                result.fix_previous      = 1'b1;
                                result.previous_position = prev_wide[POS_W-1:0];
                                result.previous_form     = entry.prev_form;
                            end
                            previous_index_next    = pos;
                            ctl_next.have_previous = 1'b1;
                            ctl_next.joining_state = entry.state_after;
                        end
                    end
                end
            end

            KIND_POST:
            begin
                ctl_next.phase         = PH_POST;
                ctl_next.context_done  = post_done;
                context_inspected_next = post_inspected;
                // First non-transparent post-context character may fix the last one.
                if (!post_done && post_inspected < CTX_W'(CONTEXT_LIMIT))
                begin
                    context_inspected_next = post_inspected + 1'b1;
                    if (!transparent)
                    begin
                        ctl_next.context_done = 1'b1;
                        if (entry.prev_form != F_NONE && ctl.have_previous)
                        begin
                            result.valid             = 1'b1;
                            result.fix_previous      = 1'b1;
                            result.previous_position = prev_wide[POS_W-1:0];
                            result.previous_form     = entry.prev_form;
                        end
                    end
                end
            end

            default:
            begin
                ctl_next = ctl;
            end
        endcase
    end

endmodule

>>> hdl/arabic_joining_form_assigner.sv
// Top level of the Arabic joining form assigner with input and result registers.
//
// The block takes one character beat per clock cycle while the master side
// takes results, and gives each text character its positional form from a
// seven-state joining machine, together with an optional rewrite of the
// previous non-transparent character. A beat accepted on the slave side lands
// in an input register; the table lookup and state update are then applied
// to it and any result is written into the result register, which is
// presented on the master side. One beat per cycle is sustained for as long
// as the master side takes results. The rate is limited by the loop through
// the joining state register and the table. While a result waits on the
// master side, one further beat can still be taken into the input register.
// Beats that produce no result (start of run, context characters, ignored
// characters) still pass through the machine. There is no clearing pass
// after reset.
module arabic_joining_form_assigner
    import ajfa_pkg::*;
#(
    parameter int MAX_RUN       = MAX_RUN_DEF,
    parameter int CONTEXT_LIMIT = CONTEXT_LIMIT_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // Fields from bit 0 up: joining_type[2:0], zero fill[7:3].
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // Fields from bit 0 up: kind[1:0].
    input  logic [S_TUSER_W-1:0]  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // Fields from bit 0 up: current_form[2:0], text_position[14:3],
    // previous_position[26:15], previous_form[29:27], zero fill[31:30].
    output logic [M_TDATA_W-1:0]  m_tdata,
    // Fields from bit 0 up: fix_previous[0].
    output logic [M_TUSER_W-1:0]  m_tuser
);

    localparam int CNT_W = $clog2(MAX_RUN + 1);
    localparam int IDX_W = $clog2(MAX_RUN);
    localparam int CTX_W = $clog2(CONTEXT_LIMIT + 1);

    logic              in_valid_reg;
    logic              in_valid_next;
    kind_t             in_kind_reg;
    logic [JT_W-1:0]   in_jt_reg;

    ctl_t              ctl_reg;
    ctl_t              ctl_next;
    logic [CNT_W-1:0]  text_counter_reg;
    logic [CNT_W-1:0]  text_counter_next;
    logic [IDX_W-1:0]  previous_index_reg;
    logic [IDX_W-1:0]  previous_index_next;
    logic [CTX_W-1:0]  context_inspected_reg;
    logic [CTX_W-1:0]  context_inspected_next;

    res_t              step_res;
    res_t              res_reg;
    logic              out_valid_reg;
    logic              out_valid_next;

    logic              s_fire;
    logic              advance;

    // Joining machine step on the registered character.
    ajfa_step #(
        .MAX_RUN       (MAX_RUN),
        .CONTEXT_LIMIT (CONTEXT_LIMIT)
    ) u_step (
        .kind                   (in_kind_reg),
        .joining_type           (in_jt_reg),
        .ctl                    (ctl_reg),
        .text_counter           (text_counter_reg),
        .previous_index         (previous_index_reg),
        .context_inspected      (context_inspected_reg),
        .ctl_next               (ctl_next),
        .text_counter_next      (text_counter_next),
        .previous_index_next    (previous_index_next),
        .context_inspected_next (context_inspected_next),
        .result                 (step_res)
    );

    // The registered character moves on unless its result would overwrite a waiting one.
    assign advance  = in_valid_reg && (!step_res.valid || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    // Valid flags of the input and result registers.
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_fire)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance && step_res.valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg          <= 1'b0;
            out_valid_reg         <= 1'b0;
            ctl_reg.joining_state <= JS_START;
            ctl_reg.have_previous <= 1'b0;
            ctl_reg.context_done  <= 1'b0;
            ctl_reg.phase         <= PH_BEFORE;
            text_counter_reg      <= '0;
            previous_index_reg    <= '0;
            context_inspected_reg <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                ctl_reg               <= ctl_next;
                text_counter_reg      <= text_counter_next;
                previous_index_reg    <= previous_index_next;
                context_inspected_reg <= context_inspected_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_kind_reg <= kind_t'(s_tuser[KIND_W-1:0]);
            in_jt_reg   <= s_tdata[JT_W-1:0];
        end
        if (advance && step_res.valid)
        begin
            res_reg <= step_res;
        end
    end

    // Master-side beat.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, res_reg.previous_form, res_reg.previous_position,
                       res_reg.text_position, res_reg.current_form};
    assign m_tuser  = res_reg.fix_previous;

endmodule

>>> hdl/ajfa_checker.sv
// Port-level checker for the Arabic joining form assigner and its bind.
module ajfa_checker
    import ajfa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,
    input  logic [M_TUSER_W-1:0]  m_tuser
);

    // A stalled result beat holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("ajfa: stalled result beat changed");

    // Without a rewrite the previous-character fields are zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[29:15] == 15'd0)
    else $error("ajfa: previous fields set without fix_previous");

    // A rewrite always carries a real form.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[29:27] != F_NONE)
    else $error("ajfa: fix_previous with empty form");

    // With no result waiting, the slave side is always open.
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
    else $error("ajfa: input stalled with empty result register");

    // A fresh result follows an accepted beat through the input and result registers.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("ajfa: result without a matching input beat");

endmodule

bind arabic_joining_form_assigner ajfa_checker u_ajfa_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
